[hdl/text_console_writer_assert.svh]
// Assertion macros used by the console RTL.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define TCW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

  // Width of the cursor and cell index fields
  localparam int POS_W = 11;

  // Character codes with special handling
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  // Attribute used for scrolled rows after reset
  localparam logic [7:0] DEF_ATTR_RST = 8'd15;

  // Operation codes
  typedef enum logic [1:0] {
    FUNC_PRINT      = 2'd0,
    FUNC_BACKSPACE  = 2'd1,
    FUNC_SET_CURSOR = 2'd2,
    FUNC_READ       = 2'd3
  } tcw_func_t;

  // One screen cell: attribute in the high byte, character in the low byte
  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] ch;
  } tcw_cell_t;

endpackage

`default_nettype wire

[hdl/tcw_cell_ram.sv]
`default_nettype none

// Screen cell store: one write port, one read port, registered read data.
module tcw_cell_ram #(
  parameter int DEPTH  = 3200,
  parameter int ADDR_W = 12
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [ADDR_W-1:0]        waddr,
  input  wire tcw_pkg::tcw_cell_t wdata,
  input  wire [ADDR_W-1:0]        raddr,
  output tcw_pkg::tcw_cell_t      rdata
);

  tcw_pkg::tcw_cell_t mem [DEPTH];
  tcw_pkg::tcw_cell_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hdl/text_console_writer.sv]
// Print and backspace write one cell and tab writes TAB cells, each into the cell RAM;
//   newline without a scroll, return, backspace at the origin and a read past the end write none.
// Each scroll blanks the bottom row, one bottom-row cell per cycle.
// Set cursor and read cell find the row by repeated subtraction (one subtract per row).
// One item in flight; the next is taken the cycle after its result enters the output register.
// Reset: synchronous active-low, then the cell RAM is cleared (in_tready low).
`default_nettype none
`include "text_console_writer_assert.svh"

module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int TAB     = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  // in_tdata: [7:0] char_code, [15:8] attribute, [26:16] position, rest zero
  input  wire  [31:0] in_tdata,
  // in_tuser: [1:0] func
  input  wire  [1:0]  in_tuser,
  input  wire         in_tvalid,
  output logic        in_tready,
  // out_tdata: [10:0] cursor_position, [18:11] cell_char,
  //            [26:19] cell_attribute, [27] scrolled, rest zero
  output logic [31:0] out_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  input  wire  [7:0]  cfg_data,
  input  wire         cfg_valid,
  output logic        cfg_ready
);

  localparam int POS_W     = tcw_pkg::POS_W;
  localparam int CW        = $clog2(COLUMNS);
  localparam int PRW       = $clog2(ROWS);
  localparam int RW        = $clog2(ROWS + 1);
  localparam int TCW       = $clog2(TAB + 1);
  localparam int ADDR_W    = PRW + CW;
  localparam int MEM_DEPTH = ROWS * (2 ** CW);
  localparam int CELLS     = COLUMNS * ROWS;

  localparam logic [CW-1:0]    COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0]    ROW_END   = RW'(ROWS);
  localparam logic [RW-1:0]    ROW_LAST  = RW'(ROWS - 1);
  localparam logic [PRW-1:0]   PROW_LAST = PRW'(ROWS - 1);
  localparam logic [RW:0]      ROWS_WIDE = (RW + 1)'(ROWS);
  localparam logic [POS_W-1:0] CELLS_P   = POS_W'(CELLS);
  localparam logic [POS_W-1:0] COLS_P    = POS_W'(COLUMNS);
  localparam logic [TCW-1:0]   TAB_CNT   = TCW'(TAB);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PUT, S_SCROLL, S_DIV, S_RD, S_RDW, S_FINISH
  } state_t;

  // Input fields
  logic [7:0]          in_char;
  logic [7:0]          in_attr;
  logic [POS_W-1:0]    in_pos;
  tcw_pkg::tcw_func_t  in_func;

  assign in_char = in_tdata[7:0];
  assign in_attr = in_tdata[15:8];
  assign in_pos  = in_tdata[26:16];
  assign in_func = tcw_pkg::tcw_func_t'(in_tuser);

  // Registers and next values
  state_t           state_r, state_nxt;
  logic [RW-1:0]    cur_row_r, cur_row_nxt;
  logic [CW-1:0]    cur_col_r, cur_col_nxt;
  logic [PRW-1:0]   base_r, base_nxt;
  logic [PRW-1:0]   clr_prow_r, clr_prow_nxt;
  logic [CW-1:0]    clr_col_r, clr_col_nxt;
  logic [TCW-1:0]   tab_cnt_r, tab_cnt_nxt;
  logic             bs_r, bs_nxt;
  logic [7:0]       wch_r, wch_nxt;
  logic [7:0]       wattr_r, wattr_nxt;
  logic [7:0]       sattr_r, sattr_nxt;
  logic             sret_put_r, sret_put_nxt;
  logic             scrolled_r, scrolled_nxt;
  logic [POS_W-1:0] div_rem_r, div_rem_nxt;
  logic [RW-1:0]    div_row_r, div_row_nxt;
  logic             div_read_r, div_read_nxt;
  logic [7:0]       rd_ch_r, rd_ch_nxt;
  logic [7:0]       rd_attr_r, rd_attr_nxt;
  logic [7:0]       def_attr_r, def_attr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [POS_W-1:0] out_cursor_r, out_cursor_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic [7:0]       out_attr_r, out_attr_nxt;
  logic             out_scrolled_r, out_scrolled_nxt;

  // RAM ports
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ADDR_W-1:0]  mem_raddr;
  tcw_pkg::tcw_cell_t mem_wdata;
  tcw_pkg::tcw_cell_t mem_rdata;

  tcw_cell_ram #(
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Logical row to physical row: rows rotate by base_r on each scroll
  logic [RW-1:0] sel_row;
  logic [RW:0]   phys_sum;
  logic [RW:0]   phys_full;
  logic [PRW-1:0] phys_row;

  always_comb begin
    sel_row   = (state_r == S_RD) ? div_row_r : cur_row_r;
    phys_sum  = (RW + 1)'(base_r) + (RW + 1)'(sel_row);
    phys_full = (phys_sum >= ROWS_WIDE) ? (phys_sum - ROWS_WIDE) : phys_sum;
    phys_row  = phys_full[PRW-1:0];
  end

  assign mem_raddr = {phys_row, div_rem_r[CW-1:0]};

  // Linear cursor for the result
  logic [POS_W-1:0] cursor_lin;
  assign cursor_lin = POS_W'(cur_row_r * COLUMNS) + POS_W'(cur_col_r);

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    cur_row_nxt      = cur_row_r;
    cur_col_nxt      = cur_col_r;
    base_nxt         = base_r;
    clr_prow_nxt     = clr_prow_r;
    clr_col_nxt      = clr_col_r;
    tab_cnt_nxt      = tab_cnt_r;
    bs_nxt           = bs_r;
    wch_nxt          = wch_r;
    wattr_nxt        = wattr_r;
    sattr_nxt        = sattr_r;
    sret_put_nxt     = sret_put_r;
    scrolled_nxt     = scrolled_r;
    div_rem_nxt      = div_rem_r;
    div_row_nxt      = div_row_r;
    div_read_nxt     = div_read_r;
    rd_ch_nxt        = rd_ch_r;
    rd_attr_nxt      = rd_attr_r;
    def_attr_nxt     = cfg_valid ? cfg_data : def_attr_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_cursor_nxt   = out_cursor_r;
    out_char_nxt     = out_char_r;
    out_attr_nxt     = out_attr_r;
    out_scrolled_nxt = out_scrolled_r;
    mem_we           = 1'b0;
    mem_waddr        = {phys_row, cur_col_r};
    mem_wdata        = '{attr: wattr_r, ch: wch_r};

    case (state_r)
      // Zero every visible cell, one per cycle
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = {clr_prow_r, clr_col_r};
        mem_wdata   = '0;
        clr_col_nxt = clr_col_r + 1'b1;
        if (clr_col_r == COL_LAST) begin
          clr_col_nxt  = '0;
          clr_prow_nxt = clr_prow_r + 1'b1;
          if (clr_prow_r == PROW_LAST) begin
            state_nxt = S_IDLE;
          end
        end
      end

      // Decode a new item
      S_IDLE: begin
        clr_col_nxt = '0;
        if (in_tvalid) begin
          scrolled_nxt = 1'b0;
          rd_ch_nxt    = '0;
          rd_attr_nxt  = '0;
          bs_nxt       = 1'b0;
          wattr_nxt    = in_attr;
          case (in_func)
            tcw_pkg::FUNC_PRINT: begin
              if (in_char == tcw_pkg::CH_NEWLINE) begin
                cur_col_nxt = '0;
                if (cur_row_r >= ROW_LAST) begin
                  sattr_nxt    = def_attr_r;
                  sret_put_nxt = 1'b0;
                  state_nxt    = S_SCROLL;
                end else begin
                  cur_row_nxt = cur_row_r + 1'b1;
                  state_nxt   = S_FINISH;
                end
              end else if (in_char == tcw_pkg::CH_RETURN) begin
                cur_col_nxt = '0;
                state_nxt   = S_FINISH;
              end else if (in_char == tcw_pkg::CH_TAB) begin
                tab_cnt_nxt = TAB_CNT;
                wch_nxt     = tcw_pkg::CH_SPACE;
                sattr_nxt   = in_attr;
                state_nxt   = S_PUT;
              end else begin
                tab_cnt_nxt = TCW'(1);
                wch_nxt     = in_char;
                sattr_nxt   = def_attr_r;
                state_nxt   = S_PUT;
              end
            end
            tcw_pkg::FUNC_BACKSPACE: begin
              if (cur_row_r == '0 && cur_col_r == '0) begin
                state_nxt = S_FINISH;
              end else begin
                if (cur_col_r == '0) begin
                  cur_col_nxt = COL_LAST;
                  cur_row_nxt = cur_row_r - 1'b1;
                end else begin
                  cur_col_nxt = cur_col_r - 1'b1;
                end
                bs_nxt      = 1'b1;
                tab_cnt_nxt = TCW'(1);
                wch_nxt     = tcw_pkg::CH_SPACE;
                state_nxt   = S_PUT;
              end
            end
            tcw_pkg::FUNC_SET_CURSOR: begin
              div_rem_nxt  = (in_pos > CELLS_P) ? CELLS_P : in_pos;
              div_row_nxt  = '0;
              div_read_nxt = 1'b0;
              state_nxt    = S_DIV;
            end
            default: begin
              if (in_pos < CELLS_P) begin
                div_rem_nxt  = in_pos;
                div_row_nxt  = '0;
                div_read_nxt = 1'b1;
                state_nxt    = S_DIV;
              end else begin
                state_nxt = S_FINISH;
              end
            end
          endcase
        end
      end

      // Write cells at the cursor, scrolling first when past the end
      S_PUT: begin
        if (tab_cnt_r == '0) begin
          state_nxt = S_FINISH;
        end else if (cur_row_r == ROW_END) begin
          cur_row_nxt  = ROW_LAST;
          sret_put_nxt = 1'b1;
          clr_col_nxt  = '0;
          state_nxt    = S_SCROLL;
        end else begin
          mem_we      = 1'b1;
          tab_cnt_nxt = tab_cnt_r - 1'b1;
          if (!bs_r) begin
            if (cur_col_r == COL_LAST) begin
              cur_col_nxt = '0;
              cur_row_nxt = cur_row_r + 1'b1;
            end else begin
              cur_col_nxt = cur_col_r + 1'b1;
            end
          end
        end
      end

      // Blank the old top row, which becomes the new bottom row
      S_SCROLL: begin
        mem_we      = 1'b1;
        mem_waddr   = {base_r, clr_col_r};
        mem_wdata   = '{attr: sattr_r, ch: tcw_pkg::CH_SPACE};
        clr_col_nxt = clr_col_r + 1'b1;
        if (clr_col_r == COL_LAST) begin
          clr_col_nxt  = '0;
          base_nxt     = (base_r == PROW_LAST) ? '0 : base_r + 1'b1;
          scrolled_nxt = 1'b1;
          state_nxt    = sret_put_r ? S_PUT : S_FINISH;
        end
      end

      // Row and column of a position by repeated subtraction
      S_DIV: begin
        if (div_rem_r >= COLS_P) begin
          div_rem_nxt = div_rem_r - COLS_P;
          div_row_nxt = div_row_r + 1'b1;
        end else if (div_read_r) begin
          state_nxt = S_RD;
        end else begin
          cur_row_nxt = div_row_r;
          cur_col_nxt = div_rem_r[CW-1:0];
          state_nxt   = S_FINISH;
        end
      end

      // Read address is presented this cycle
      S_RD: begin
        state_nxt = S_RDW;
      end

      S_RDW: begin
        rd_ch_nxt   = mem_rdata.ch;
        rd_attr_nxt = mem_rdata.attr;
        state_nxt   = S_FINISH;
      end

      // Queue the result once the output register is free
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt    = 1'b1;
          out_cursor_nxt   = cursor_lin;
          out_char_nxt     = rd_ch_r;
          out_attr_nxt     = rd_attr_r;
          out_scrolled_nxt = scrolled_r;
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      base_r      <= '0;
      clr_prow_r  <= '0;
      clr_col_r   <= '0;
      tab_cnt_r   <= '0;
      def_attr_r  <= tcw_pkg::DEF_ATTR_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      base_r      <= base_nxt;
      clr_prow_r  <= clr_prow_nxt;
      clr_col_r   <= clr_col_nxt;
      tab_cnt_r   <= tab_cnt_nxt;
      def_attr_r  <= def_attr_nxt;
      out_valid_r <= out_valid_nxt;
      // payload
      bs_r           <= bs_nxt;
      wch_r          <= wch_nxt;
      wattr_r        <= wattr_nxt;
      sattr_r        <= sattr_nxt;
      sret_put_r     <= sret_put_nxt;
      scrolled_r     <= scrolled_nxt;
      div_rem_r      <= div_rem_nxt;
      div_row_r      <= div_row_nxt;
      div_read_r     <= div_read_nxt;
      rd_ch_r        <= rd_ch_nxt;
      rd_attr_r      <= rd_attr_nxt;
      out_cursor_r   <= out_cursor_nxt;
      out_char_r     <= out_char_nxt;
      out_attr_r     <= out_attr_nxt;
      out_scrolled_r <= out_scrolled_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_scrolled_r, out_attr_r, out_char_r, out_cursor_r};

  // Checks
  `TCW_ASSERT_SAME(a_cursor_end, clk, rst_n, (cur_row_r == ROW_END), (cur_col_r == '0), "cursor past end with nonzero column")
  `TCW_ASSERT_NEXT(a_one_item, clk, rst_n, (in_tvalid && in_tready), (!in_tready), "second item taken while one is in flight")
  `TCW_ASSERT_SAME(a_wr_row, clk, rst_n, mem_we, ({1'b0, mem_waddr[ADDR_W-1:CW]} < (PRW + 1)'(ROWS)), "cell write outside screen rows")
  `TCW_ASSERT_NEXT(a_scroll_flag, clk, rst_n, (state_r == S_SCROLL && clr_col_r == COL_LAST), scrolled_r, "scroll finished without flag")

endmodule

`default_nettype wire

[tb/text_console_writer_tb.sv]
`timescale 1ns / 1ps

module text_console_writer_tb;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int TAB = 4;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int MAX_IDLE = 18;
  localparam int CYCLE_LIMIT = 900_000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS = 260;
  localparam int BURST_LEN = 40;

  // One console report: cursor after the step plus read-back cell
  typedef struct {
    logic [tcw_pkg::POS_W-1:0] cursor;
    logic [7:0]                ch;
    logic [7:0]                attr;
    logic                      scrolled;
  } console_report_t;

  // Screen image, cursor and scroll attribute, plus the reports still owed
  class console_screen_model;
    tcw_pkg::tcw_cell_t cells [CELL_COUNT];
    int unsigned        cursor;
    logic [7:0]         scroll_attr;
    console_report_t    pending_reports [$];
    int                 mismatch_count;

    function new();
      foreach (cells[i]) cells[i] = '0;
      cursor = 0;
      scroll_attr = tcw_pkg::DEF_ATTR_RST;
      mismatch_count = 0;
    endfunction

    function void put_cell(int unsigned pos, logic [7:0] c, logic [7:0] a);
      if (pos < CELL_COUNT) cells[pos] = {a, c};
    endfunction

    // Shift every row up one and blank the bottom row
    function void scroll_up(logic [7:0] a);
      for (int i = 0; i + COLUMNS < CELL_COUNT; i++) cells[i] = cells[i + COLUMNS];
      for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
        cells[i] = {a, tcw_pkg::CH_SPACE};
    endfunction

    // Scroll once if the cursor sits at or past the end
    function bit make_room(logic [7:0] a);
      if (cursor < CELL_COUNT) return 1'b0;
      scroll_up(a);
      cursor -= COLUMNS;
      return 1'b1;
    endfunction

    function void set_scroll_attr(logic [7:0] a);
      scroll_attr = a;
    endfunction

    // Update the screen for one accepted item and queue its report
    function void apply_item(tcw_pkg::tcw_func_t func, logic [7:0] c, logic [7:0] a,
                             logic [tcw_pkg::POS_W-1:0] pos);
      console_report_t rep;
      rep.ch = '0;
      rep.attr = '0;
      rep.scrolled = 1'b0;
      case (func)
        tcw_pkg::FUNC_PRINT: begin
          if (c == tcw_pkg::CH_NEWLINE) begin
            cursor += COLUMNS;
            rep.scrolled = make_room(scroll_attr);
            cursor -= cursor % COLUMNS;
          end else if (c == tcw_pkg::CH_RETURN) begin
            cursor -= cursor % COLUMNS;
          end else if (c == tcw_pkg::CH_TAB) begin
            // tab fills with spaces and scrolls in the item's attribute
            for (int i = 0; i < TAB; i++) begin
              if (make_room(a)) rep.scrolled = 1'b1;
              put_cell(cursor, tcw_pkg::CH_SPACE, a);
              cursor++;
            end
          end else begin
            rep.scrolled = make_room(scroll_attr);
            put_cell(cursor, c, a);
            cursor++;
          end
        end
        tcw_pkg::FUNC_BACKSPACE: begin
          if (cursor > 0) begin
            cursor--;
            put_cell(cursor, tcw_pkg::CH_SPACE, a);
          end
        end
        tcw_pkg::FUNC_SET_CURSOR: begin
          cursor = (pos > CELL_COUNT) ? CELL_COUNT : pos;
        end
        default: begin
          if (pos < CELL_COUNT) begin
            rep.ch = cells[pos].ch;
            rep.attr = cells[pos].attr;
          end
        end
      endcase
      rep.cursor = tcw_pkg::POS_W'(cursor);
      pending_reports.push_back(rep);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatch_count++;
    endtask

    // Compare one transferred result against the oldest pending report
    task check_result(logic [31:0] data);
      console_report_t want;
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, tdata %h", data));
        return;
      end
      want = pending_reports.pop_front();
      if (data[10:0] !== want.cursor)
        report_mismatch($sformatf("cursor_position got %0d want %0d",
                                  data[10:0], want.cursor));
      if (data[18:11] !== want.ch)
        report_mismatch($sformatf("cell_char got %h want %h", data[18:11], want.ch));
      if (data[26:19] !== want.attr)
        report_mismatch($sformatf("cell_attribute got %h want %h",
                                  data[26:19], want.attr));
      if (data[27] !== want.scrolled)
        report_mismatch($sformatf("scrolled got %b want %b", data[27], want.scrolled));
    endtask

    task flag_leftovers();
      if (pending_reports.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", pending_reports.size()));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  cfg_data = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;

  int gap_max = MAX_IDLE;
  int stall_max = MAX_IDLE;
  int cycle_count = 0;
  console_screen_model model;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS),
    .TAB(TAB)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_data(cfg_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
  );

  always #1 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("text_console_writer verification failed");
      $finish;
    end
  end

  // Result side: random stalls, check each transfer
  initial begin : result_sink
    int stall;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, stall_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      model.check_result(out_tdata);
      @(negedge clk);
    end
  end

  // Send one item after a random gap; returns at the falling edge after transfer
  task send_item(tcw_pkg::tcw_func_t func, logic [7:0] c, logic [7:0] a,
                 logic [tcw_pkg::POS_W-1:0] pos);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {5'b0, pos, a, c};
    do @(posedge clk); while (!in_tready);
    model.apply_item(func, c, a, pos);
    @(negedge clk);
  endtask

  // Register write once the console has drained
  task write_default_attr(logic [7:0] value);
    in_tvalid <= 1'b0;
    while (model.pending_reports.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    model.set_scroll_attr(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Weighted random item, biased toward the bottom rows and recent cells
  task send_random_item();
    int unsigned pick;
    int unsigned lo;
    tcw_pkg::tcw_func_t func;
    logic [7:0] c;
    logic [7:0] a;
    logic [tcw_pkg::POS_W-1:0] pos;
    pick = $urandom_range(0, 99);
    c = 8'($urandom);
    a = 8'($urandom);
    pos = tcw_pkg::POS_W'($urandom);
    if (pick < 55) begin
      func = tcw_pkg::FUNC_PRINT;
      pick = $urandom_range(0, 19);
      if (pick < 2) c = tcw_pkg::CH_NEWLINE;
      else if (pick == 2) c = tcw_pkg::CH_RETURN;
      else if (pick < 5) c = tcw_pkg::CH_TAB;
    end else if (pick < 65) begin
      func = tcw_pkg::FUNC_BACKSPACE;
    end else if (pick < 80) begin
      func = tcw_pkg::FUNC_SET_CURSOR;
      if ($urandom_range(0, 2) != 0)
        pos = tcw_pkg::POS_W'($urandom_range(CELL_COUNT - 2 * COLUMNS,
                                             2 ** tcw_pkg::POS_W - 1));
    end else begin
      func = tcw_pkg::FUNC_READ;
      if ($urandom_range(0, 1) != 0) begin
        lo = (model.cursor > 2 * COLUMNS) ? model.cursor - 2 * COLUMNS : 0;
        pos = tcw_pkg::POS_W'($urandom_range(lo, model.cursor + 8));
      end
    end
    send_item(func, c, a, pos);
  endtask

  initial begin : stimulus
    logic [7:0] attr_setting;
    model = new();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every operation, edge-of-screen cases
    send_item(tcw_pkg::FUNC_READ, 8'($urandom), 8'($urandom), 11'd0);
    send_item(tcw_pkg::FUNC_PRINT, 8'd65, 8'hFF, tcw_pkg::POS_W'($urandom));
    send_item(tcw_pkg::FUNC_PRINT, 8'hFF, 8'h00, tcw_pkg::POS_W'($urandom));
    send_item(tcw_pkg::FUNC_PRINT, 8'h00, 8'h80, tcw_pkg::POS_W'($urandom));
    send_item(tcw_pkg::FUNC_READ, 8'hFF, 8'hFF, 11'd0);
    send_item(tcw_pkg::FUNC_READ, 8'h00, 8'h00, 11'd2);
    send_item(tcw_pkg::FUNC_BACKSPACE, 8'($urandom), 8'h5A, tcw_pkg::POS_W'($urandom));
    send_item(tcw_pkg::FUNC_READ, 8'($urandom), 8'($urandom), 11'd2);
    send_item(tcw_pkg::FUNC_SET_CURSOR, 8'($urandom), 8'($urandom), 11'd0);
    // backspace at the origin leaves everything alone
    send_item(tcw_pkg::FUNC_BACKSPACE, 8'($urandom), 8'h11, tcw_pkg::POS_W'($urandom));
    send_item(tcw_pkg::FUNC_PRINT, tcw_pkg::CH_RETURN, 8'($urandom),
              tcw_pkg::POS_W'($urandom));
    send_item(tcw_pkg::FUNC_PRINT, tcw_pkg::CH_TAB, 8'h33, tcw_pkg::POS_W'($urandom));
    send_item(tcw_pkg::FUNC_PRINT, tcw_pkg::CH_RETURN, 8'($urandom),
              tcw_pkg::POS_W'($urandom));
    send_item(tcw_pkg::FUNC_PRINT, tcw_pkg::CH_NEWLINE, 8'($urandom),
              tcw_pkg::POS_W'($urandom));
    // set cursor saturates; reads past the end return zero
    send_item(tcw_pkg::FUNC_SET_CURSOR, 8'($urandom), 8'($urandom), 11'h7FF);
    send_item(tcw_pkg::FUNC_READ, 8'($urandom), 8'($urandom), 11'(CELL_COUNT));
    send_item(tcw_pkg::FUNC_READ, 8'($urandom), 8'($urandom), 11'h7FF);
    // newline past the end scrolls and stays past the end
    send_item(tcw_pkg::FUNC_PRINT, tcw_pkg::CH_NEWLINE, 8'($urandom),
              tcw_pkg::POS_W'($urandom));
    send_item(tcw_pkg::FUNC_PRINT, 8'd90, 8'h4E, tcw_pkg::POS_W'($urandom));
    send_item(tcw_pkg::FUNC_READ, 8'($urandom), 8'($urandom),
              11'(CELL_COUNT - COLUMNS + 1));
    // tab that scrolls partway through
    send_item(tcw_pkg::FUNC_SET_CURSOR, 8'($urandom), 8'($urandom), 11'(CELL_COUNT - 2));
    send_item(tcw_pkg::FUNC_PRINT, tcw_pkg::CH_TAB, 8'hC3, tcw_pkg::POS_W'($urandom));
    send_item(tcw_pkg::FUNC_READ, 8'($urandom), 8'($urandom),
              11'(CELL_COUNT - COLUMNS - 1));
    // newline on the last cell scrolls and lands at the bottom row
    send_item(tcw_pkg::FUNC_SET_CURSOR, 8'($urandom), 8'($urandom), 11'(CELL_COUNT - 1));
    send_item(tcw_pkg::FUNC_PRINT, tcw_pkg::CH_NEWLINE, 8'($urandom),
              tcw_pkg::POS_W'($urandom));
    send_item(tcw_pkg::FUNC_SET_CURSOR, 8'($urandom), 8'($urandom), 11'(CELL_COUNT));
    send_item(tcw_pkg::FUNC_BACKSPACE, 8'($urandom), 8'hA5, tcw_pkg::POS_W'($urandom));

    // Random phases, each under its own scroll attribute
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: attr_setting = 8'h00;
        1: attr_setting = 8'hFF;
        4: attr_setting = tcw_pkg::DEF_ATTR_RST;
        default: attr_setting = 8'($urandom);
      endcase
      write_default_attr(attr_setting);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // each burst picks at random between back-to-back items and idling on either side
        if (n % BURST_LEN == 0) begin
          gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_IDLE;
          stall_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_IDLE;
        end
        send_random_item();
      end
    end

    // Drain, then give the console time to show any stray result
    in_tvalid <= 1'b0;
    while (model.pending_reports.size() != 0) @(negedge clk);
    repeat (COLUMNS + ROWS + 16) @(negedge clk);
    model.flag_leftovers();
    if (model.mismatch_count == 0) begin
      $display("text_console_writer verification clean");
    end else begin
      $display("text_console_writer verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_cell_ram.sv
hdl/text_console_writer.sv
tb/text_console_writer_tb.sv
